// ===== hw/rtl/rfr_pkg.sv =====
// Package for the rational FIR resampler: sizes, register map, helpers.
// No dependencies.
`timescale 1ns / 1ps
package rfr_pkg;
  localparam int unsigned MaxTaps   = 512;
  localparam int unsigned MaxInterp = 64;
  localparam int unsigned MaxDecim  = 128;
  localparam int unsigned PtrW      = $clog2(MaxTaps);
  localparam int unsigned AccW      = 52;

  localparam logic [1:0] RegInterp = 2'd0;
  localparam logic [1:0] RegDecim  = 2'd1;
  localparam logic [1:0] RegTaps   = 2'd2;

  localparam logic OpSample = 1'b0;
  localparam logic OpCoef   = 1'b1;

  typedef struct packed {
    logic        op;
    logic        block_start;
    logic [23:0] sample_in;
    logic [8:0]  coef_index;
    logic [17:0] coef_value;
  } in_item_t;

  typedef struct packed {
    logic [23:0] sample_out;
    logic        last;
  } out_item_t;

  // Round half up by 2^16, saturate to 24 bits.
  function automatic logic [23:0] round_sat(input logic signed [AccW-1:0] acc);
    logic signed [AccW-1:0] r;
    logic signed [AccW-17:0] s;
    r = acc + AccW'(32768);
    s = r[AccW-1:16];
    if (s > $signed((AccW-16)'(24'sh7FFFFF))) return 24'h7FFFFF;
    if (s < -$signed((AccW-16)'(25'sh800000))) return 24'h800000;
    return s[23:0];
  endfunction
endpackage

// ===== hw/rtl/rfr_stream_if.sv =====
// Valid/ready channel interface carrying one payload.
// No dependencies; the payload type is given by parameter T.
`timescale 1ns / 1ps
interface rfr_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/rfr_mac.sv =====
// Shared multiply-accumulate unit: 24x18 product registered, then summed.
// Depends on rfr_pkg.
`timescale 1ns / 1ps
module rfr_mac import rfr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   clr_i,
  input  logic                   en_i,
  input  logic signed [23:0]     a_i,
  input  logic signed [17:0]     b_i,
  output logic signed [AccW-1:0] acc_o
);
  logic signed [41:0]     prod_q;
  logic                   pv_q;
  logic signed [AccW-1:0] acc_q;

  // product stage then accumulate stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q  <= 1'b0;
      acc_q <= '0;
    end else begin
      pv_q <= en_i;
      if (clr_i) acc_q <= '0;
      else if (pv_q) acc_q <= acc_q + AccW'(prod_q);
    end
  end
  always_ff @(posedge clk_i) prod_q <= a_i * b_i;
  assign acc_o = acc_q;
endmodule

// ===== hw/rtl/rational_fir_resampler_unit.sv =====
// Top level of the rational L/M FIR resampler: APB registers, sequencer,
// history and coefficient memories. Depends on rfr_pkg, rfr_stream_if, rfr_mac.
//
// One audio sample takes L slots; each slot with L>1 runs an up-stage FIR of
// tap_count multiply-accumulates, and each kept slot (M>1) a down-stage FIR
// of tap_count more, all through one shared multiplier fed by one read port
// per memory. A coefficient item is written into the coefficient memory when
// it is accepted. A block_start runs a clearing pass over all 512 entries of
// both history memories before the sample. After reset a clearing pass runs
// before the first item is taken. L=M=1 passes the sample without any FIR.
`timescale 1ns / 1ps
module rational_fir_resampler_unit import rfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  rfr_stream_if.sink   in_if,
  rfr_stream_if.source out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam logic [3:0] StClr  = 4'd0;
  localparam logic [3:0] StIdle = 4'd1;
  localparam logic [3:0] StSlot = 4'd2;
  localparam logic [3:0] StUpF  = 4'd3;
  localparam logic [3:0] StUpW  = 4'd4;
  localparam logic [3:0] StDnW  = 4'd5;
  localparam logic [3:0] StDnF  = 4'd6;
  localparam logic [3:0] StDnE  = 4'd7;
  localparam logic [3:0] StOut  = 4'd8;
  localparam logic [3:0] StNext = 4'd9;
  localparam logic [3:0] StUpE  = 4'd10;

  // configuration registers
  logic [6:0] interp_q;
  logic [7:0] decim_q;
  logic [9:0] taps_q;
  logic [1:0] reg_idx;
  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interp_q <= 7'd1;
      decim_q  <= 8'd1;
      taps_q   <= 10'd64;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00 && !paddr[3] ||
                 psel && penable && pwrite && paddr == 4'd8) begin
      case (reg_idx)
        RegInterp: interp_q <= pwdata[6:0];
        RegDecim:  decim_q  <= pwdata[7:0];
        RegTaps:   taps_q   <= pwdata[9:0];
        default:   ;
      endcase
    end
  end
  always_comb begin
    case (reg_idx)
      RegInterp: prdata = {25'd0, interp_q};
      RegDecim:  prdata = {24'd0, decim_q};
      RegTaps:   prdata = {22'd0, taps_q};
      default:   prdata = '0;
    endcase
  end

  // effective factors
  logic [6:0] l_eff;
  logic [7:0] m_eff;
  logic [9:0] n_eff;
  assign l_eff = (interp_q == 7'd0) ? 7'd1 : (interp_q > 7'(MaxInterp)) ? 7'(MaxInterp)
               : interp_q;
  assign m_eff = (decim_q == 8'd0) ? 8'd1 : (decim_q > 8'(MaxDecim)) ? 8'(MaxDecim)
               : decim_q;
  assign n_eff = (taps_q < 10'd8) ? 10'd8 : (taps_q > 10'(MaxTaps)) ? 10'(MaxTaps)
               : taps_q;

  // memories
  logic signed [17:0] coef_mem [MaxTaps];
  logic signed [23:0] up_mem   [MaxTaps];
  logic signed [23:0] dn_mem   [MaxTaps];
  logic signed [17:0] coef_rd_q;
  logic signed [23:0] up_rd_q, dn_rd_q;

  logic [3:0]      st_q, st_d;
  logic [PtrW-1:0] ptr_q;
  logic [PtrW:0]   cnt_q;
  logic [6:0]      slot_q, dphase_q;
  logic            bs_q;
  logic            updn_q;
  logic [5:0]      drain_q;
  logic signed [23:0] x_q, v_q, res_q;
  in_item_t        item;
  logic [PtrW-1:0] rd_addr;
  logic signed [AccW-1:0] acc;
  logic            mac_clr, mac_en;
  logic signed [23:0] mac_a;
  logic signed [30:0] xl;
  logic signed [23:0] xl_sat;
  logic            out_v_q;
  out_item_t       out_q;

  assign item = in_if.data;
  assign in_if.ready = (st_q == StIdle) && !out_v_q;
  assign out_if.valid = out_v_q;
  assign out_if.data  = out_q;

  assign xl = x_q * $signed({1'b0, l_eff});
  assign xl_sat = (xl > 31'sd8388607) ? 24'h7FFFFF : (xl < -31'sd8388608) ? 24'h800000
                : xl[23:0];

  assign rd_addr = ptr_q - cnt_q[PtrW-1:0];

  always_ff @(posedge clk_i) begin
    coef_rd_q <= coef_mem[cnt_q[PtrW-1:0]];
    up_rd_q   <= up_mem[rd_addr];
    dn_rd_q   <= dn_mem[rd_addr];
    if (in_if.valid && in_if.ready && item.op == OpCoef)
      coef_mem[item.coef_index] <= item.coef_value;
    if (st_q == StClr) begin
      up_mem[cnt_q[PtrW-1:0]] <= '0;
      dn_mem[cnt_q[PtrW-1:0]] <= '0;
    end else if (st_q == StSlot && l_eff != 7'd1) begin
      up_mem[ptr_q] <= (slot_q == 7'd0) ? xl_sat : '0;
    end else if (st_q == StDnW) begin
      dn_mem[ptr_q] <= v_q;
    end
  end

  assign mac_en  = (st_q == StUpF || st_q == StDnF) && drain_q == 6'd0 &&
                   cnt_q != {1'b0, n_eff[PtrW-1:0]} + {n_eff[PtrW], {PtrW{1'b0}}} && updn_q;
  assign mac_clr = (st_q == StUpW) || (st_q == StDnW) || (st_q == StSlot);
  assign mac_a   = (st_q == StUpF) ? up_rd_q : dn_rd_q;

  // read data is registered after the address; enable registered to match
  logic mac_en_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mac_en_q <= 1'b0;
    else mac_en_q <= mac_en;
  end

  rfr_mac u_mac (
    .clk_i (clk_i), .rst_ni(rst_ni), .clr_i(mac_clr), .en_i(mac_en_q),
    .a_i(mac_a), .b_i(coef_rd_q), .acc_o(acc)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClr; cnt_q <= '0; ptr_q <= '0; slot_q <= '0; dphase_q <= '0;
      bs_q <= 1'b0; updn_q <= 1'b0; drain_q <= '0; out_v_q <= 1'b0;
      x_q <= '0; v_q <= '0; res_q <= '0; out_q <= '0;
    end else begin
      if (out_v_q && out_if.ready) out_v_q <= 1'b0;
      case (st_q)
        StClr: begin
          if (cnt_q == 10'(MaxTaps - 1)) begin
            cnt_q <= '0; ptr_q <= '0; dphase_q <= '0;
            st_q <= bs_q ? StSlot : StIdle;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        StIdle: if (in_if.valid && in_if.ready) begin
          x_q <= item.sample_in;
          slot_q <= '0;
          if (item.op == OpSample) begin
            if (item.block_start) begin
              bs_q <= 1'b1; cnt_q <= '0; st_q <= StClr;
            end else begin
              if ({1'b0, dphase_q} >= m_eff) dphase_q <= '0;
              st_q <= StSlot;
            end
          end
        end
        StSlot: begin
          bs_q <= 1'b0;
          cnt_q <= '0; updn_q <= 1'b1; drain_q <= '0;
          if (l_eff == 7'd1 && m_eff == 8'd1) begin
            res_q <= x_q; st_q <= StOut;
          end else if (l_eff != 7'd1) st_q <= StUpF;
          else begin v_q <= x_q; st_q <= StDnW; end
        end
        StUpF, StDnF: begin
          if (updn_q) begin
            if (cnt_q == 10'(n_eff) - 10'd1) updn_q <= 1'b0;
            cnt_q <= cnt_q + 1'b1;
          end else begin
            drain_q <= drain_q + 1'b1;
            if (drain_q == 6'd4) st_q <= (st_q == StUpF) ? StUpE : StDnE;
          end
        end
        StUpE: begin
          v_q <= round_sat(acc);
          if (m_eff == 8'd1) begin res_q <= round_sat(acc); st_q <= StOut; end
          else st_q <= StDnW;
        end
        StDnW: begin
          cnt_q <= '0; updn_q <= 1'b1; drain_q <= '0;
          if (dphase_q == 7'd0) st_q <= StDnF;
          else st_q <= StNext;
        end
        StDnE: begin res_q <= round_sat(acc); st_q <= StOut; end
        StOut: if (!out_v_q) begin
          out_v_q <= 1'b1;
          out_q.sample_out <= res_q;
          out_q.last <= (slot_q == l_eff - 7'd1) ||
                        (m_eff != 8'd1 && 8'(slot_q) + 8'(m_eff - 8'(dphase_q)) >= 8'(l_eff) &&
                         ({1'b0, dphase_q} + 8'd1 == m_eff ? slot_q == l_eff - 7'd1 : 1'b1) &&
                         (8'(slot_q) + 8'(m_eff) >= 8'(l_eff)));
          // pass-through leaves the history pointer alone
          st_q <= (l_eff == 7'd1 && m_eff == 8'd1) ? StIdle : StNext;
        end
        StNext: begin
          if (m_eff != 8'd1)
            dphase_q <= ({1'b0, dphase_q} + 8'd1 == m_eff) ? 7'd0 : dphase_q + 7'd1;
          ptr_q <= ptr_q + 1'b1;
          slot_q <= slot_q + 7'd1;
          st_q <= (slot_q == l_eff - 7'd1) ? StIdle : StSlot;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  // checks
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != StIdle) |-> !in_if.ready) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.ready) |=> out_if.valid) else $error("result dropped");
  a_ptr_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StNext) |=> (ptr_q == $past(ptr_q) + 1'b1)) else $error("pointer step");
endmodule
